[rtl/as2s32_pkg.sv]
// ---------------------------------------------------------------------------
// as2s32_pkg
// Shared constants for the sample-to-s32 converter: format codes, register
// indexes, reset values and pipeline depth.
// ---------------------------------------------------------------------------
package as2s32_pkg;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned RawW      = 64;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned PipeDepth = 4;

  localparam logic [CfgIdxW-1:0] REG_FORMAT_TAG  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_BITS = 8'd1;

  localparam logic [CfgDataW-1:0] TAG_PCM   = 16'h0001;
  localparam logic [CfgDataW-1:0] TAG_FLOAT = 16'h0003;

  localparam logic [CfgDataW-1:0] FORMAT_TAG_RST  = TAG_PCM;
  localparam logic [CfgDataW-1:0] SAMPLE_BITS_RST = 16'd16;

  localparam logic [SampleW-1:0] FULL_SCALE = 32'h7FFF_FFFF;

endpackage

[rtl/audio_sample_to_s32.sv]
// ---------------------------------------------------------------------------
// audio_sample_to_s32
// Converts one raw little-endian PCM or IEEE float sample word into a
// left-justified signed 32-bit sample.
// ---------------------------------------------------------------------------
// usage:
//   input beat: raw_word_i is taken at a rising edge with start_i high and
//   busy_o low; busy_o stays low, so a beat may come every cycle.
//   result beat: sample_out_o and unsupported_o are shown for one cycle with
//   valid_o high, at the end of the pipeline, in input order.
//   throughput is one beat per cycle, set by the four-stage pipeline:
//   decode, mantissa times full scale (shift and subtract), round to double
//   precision, then align and round half away from zero.
//   config: cfg_valid_i/cfg_ready_o write channel, cfg_ready_o always high;
//   index 0 is the format tag, index 1 bits per sample, other indexes drop.
//   write config only while no beat is in flight.
//   reset: rst_ni low empties the pipeline and restores tag 1, 16 bits.
//   the receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
module audio_sample_to_s32 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [as2s32_pkg::RawW-1:0]         raw_word_i,
  output logic                                valid_o,
  output logic signed [as2s32_pkg::SampleW-1:0] sample_out_o,
  output logic                                unsupported_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [as2s32_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [as2s32_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [as2s32_pkg::CfgDataW-1:0] tag_q, bits_q;
  logic [as2s32_pkg::PipeDepth-1:0] vld_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= as2s32_pkg::FORMAT_TAG_RST;
      bits_q <= as2s32_pkg::SAMPLE_BITS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == as2s32_pkg::REG_FORMAT_TAG) tag_q <= cfg_data_i;
      else if (cfg_index_i == as2s32_pkg::REG_SAMPLE_BITS) bits_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[as2s32_pkg::PipeDepth-2:0], start_i};
    end
  end

  // stage 1: decode
  logic        bad_d, flt_d, sgn_d, nan_d, zro_d, clp_d;
  logic [31:0] pcm_d;
  logic [52:0] man_d;
  logic [4:0]  k_d;
  logic [7:0]  e8;
  logic [10:0] e11;
  logic [7:0]  k8;
  logic [10:0] k11;

  always_comb begin
    e8    = raw_word_i[30:23];
    e11   = raw_word_i[62:52];
    k8    = 8'd126 - e8;
    k11   = 11'd1022 - e11;
    bad_d = 1'b0;
    flt_d = 1'b0;
    sgn_d = 1'b0;
    nan_d = 1'b0;
    zro_d = 1'b0;
    clp_d = 1'b0;
    pcm_d = '0;
    man_d = '0;
    k_d   = '0;
    if (tag_q == as2s32_pkg::TAG_PCM) begin
      case (bits_q)
        16'd8:   pcm_d = {raw_word_i[7] ^ 1'b1, raw_word_i[6:0], 24'd0};
        16'd16:  pcm_d = {raw_word_i[15:0], 16'd0};
        16'd24:  pcm_d = {raw_word_i[23:0], 8'd0};
        16'd32:  pcm_d = raw_word_i[31:0];
        default: bad_d = 1'b1;
      endcase
    end else if (tag_q == as2s32_pkg::TAG_FLOAT && bits_q == 16'd32) begin
      flt_d = 1'b1;
      sgn_d = raw_word_i[31];
      nan_d = (e8 == 8'hFF) && (raw_word_i[22:0] != '0);
      clp_d = e8 >= 8'd127;
      zro_d = e8 < 8'd95;
      man_d = {1'b1, raw_word_i[22:0], 29'd0};
      k_d   = k8[4:0];
    end else if (tag_q == as2s32_pkg::TAG_FLOAT && bits_q == 16'd64) begin
      flt_d = 1'b1;
      sgn_d = raw_word_i[63];
      nan_d = (e11 == 11'h7FF) && (raw_word_i[51:0] != '0);
      clp_d = e11 >= 11'd1023;
      zro_d = e11 < 11'd991;
      man_d = {1'b1, raw_word_i[51:0]};
      k_d   = k11[4:0];
    end else begin
      bad_d = 1'b1;
    end
  end

  logic        bad1_q, flt1_q, sgn1_q, nan1_q, zro1_q, clp1_q;
  logic [31:0] pcm1_q;
  logic [52:0] man1_q;
  logic [4:0]  k1_q;

  always_ff @(posedge clk_i) begin
    bad1_q <= bad_d;
    flt1_q <= flt_d;
    sgn1_q <= sgn_d;
    nan1_q <= nan_d;
    zro1_q <= zro_d;
    clp1_q <= clp_d;
    pcm1_q <= pcm_d;
    man1_q <= man_d;
    k1_q   <= k_d;
  end

  // stage 2: mantissa * (2^31 - 1) as shift and subtract
  logic [83:0] prod_d;
  assign prod_d = {man1_q, 31'd0} - {31'd0, man1_q};

  logic        bad2_q, flt2_q, sgn2_q, nan2_q, zro2_q, clp2_q;
  logic [31:0] pcm2_q;
  logic [83:0] prod2_q;
  logic [4:0]  k2_q;

  always_ff @(posedge clk_i) begin
    bad2_q  <= bad1_q;
    flt2_q  <= flt1_q;
    sgn2_q  <= sgn1_q;
    nan2_q  <= nan1_q;
    zro2_q  <= zro1_q;
    clp2_q  <= clp1_q;
    pcm2_q  <= pcm1_q;
    prod2_q <= prod_d;
    k2_q    <= k1_q;
  end

  // stage 3: round product to 53 significant bits, nearest even
  logic [52:0] keep;
  logic        grd, stk;
  logic [53:0] rnd_d;

  always_comb begin
    if (prod2_q[83]) begin
      keep = prod2_q[83:31];
      grd  = prod2_q[30];
      stk  = |prod2_q[29:0];
    end else begin
      keep = prod2_q[82:30];
      grd  = prod2_q[29];
      stk  = |prod2_q[28:0];
    end
    rnd_d = {1'b0, keep} + {53'd0, grd & (stk | keep[0])};
  end

  logic        bad3_q, flt3_q, sgn3_q, nan3_q, zro3_q, clp3_q;
  logic [31:0] pcm3_q;
  logic [53:0] rnd3_q;
  logic [5:0]  sa3_q;

  always_ff @(posedge clk_i) begin
    bad3_q <= bad2_q;
    flt3_q <= flt2_q;
    sgn3_q <= sgn2_q;
    nan3_q <= nan2_q;
    zro3_q <= zro2_q;
    clp3_q <= clp2_q;
    pcm3_q <= pcm2_q;
    rnd3_q <= rnd_d;
    // shift leaves the half bit at bit 0
    sa3_q  <= 6'd21 + {1'b0, k2_q} + {5'd0, ~prod2_q[83]};
  end

  // stage 4: align, round half away from zero, clamp or zero specials, apply sign; pick PCM, or zero if unsupported
  logic [53:0] shf;
  logic [31:0] mag, res_d;

  always_comb begin
    shf = rnd3_q >> sa3_q;
    mag = shf[32:1] + {31'd0, shf[0]};
    if (clp3_q) mag = as2s32_pkg::FULL_SCALE;
    if (nan3_q || zro3_q) mag = '0;
    if (bad3_q) res_d = '0;
    else if (!flt3_q) res_d = pcm3_q;
    else if (sgn3_q) res_d = 32'd0 - mag;
    else res_d = mag;
  end

  logic [31:0] res_q;
  logic        bad4_q;

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    bad4_q <= bad3_q;
  end

  assign valid_o       = vld_q[as2s32_pkg::PipeDepth-1];
  assign sample_out_o  = res_q;
  assign unsupported_o = bad4_q;

endmodule

[rtl/as2s32_chk.sv]
// ---------------------------------------------------------------------------
// as2s32_chk
// Port-level checks for the sample converter, bound to the top level.
// ---------------------------------------------------------------------------
module as2s32_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [31:0] sample_out_o,
  input logic        unsupported_o,
  input logic        cfg_ready_o
);

  // every accepted beat yields exactly one result after the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 4) |-> (valid_o == $past(start_i && !busy_o, 4)))
    else $error("result strobe does not follow input beat");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && unsupported_o) |-> (sample_out_o == '0))
    else $error("unsupported beat with non-zero sample");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && cfg_ready_o)
    else $error("converter refused a beat");

endmodule

bind audio_sample_to_s32 as2s32_chk u_as2s32_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .sample_out_o (sample_out_o),
  .unsupported_o(unsupported_o),
  .cfg_ready_o  (cfg_ready_o)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for audio_sample_to_s32: steps through PCM and float
// formats plus unsupported pairs, sends directed edge words and random words
// in bursts, and compares every result beat with an in-bench conversion.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic signed [as2s32_pkg::SampleW-1:0] smp;
    logic                                  bad;
  } conv_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  start_i = 1'b0;
  logic [as2s32_pkg::RawW-1:0]           raw_word_i = '0;
  logic                                  cfg_valid_i = 1'b0;
  logic [as2s32_pkg::CfgIdxW-1:0]        cfg_index_i = '0;
  logic [as2s32_pkg::CfgDataW-1:0]       cfg_data_i = '0;
  logic                                  busy_o, valid_o, unsupported_o, cfg_ready_o;
  logic signed [as2s32_pkg::SampleW-1:0] sample_out_o;

  logic [as2s32_pkg::CfgDataW-1:0] cur_tag = as2s32_pkg::FORMAT_TAG_RST;
  logic [as2s32_pkg::CfgDataW-1:0] cur_bits = as2s32_pkg::SAMPLE_BITS_RST;
  logic [as2s32_pkg::RawW-1:0]     word_q[$];
  conv_t                           sample_q[$];
  int                              n_err = 0;
  int                              n_in = 0;
  int                              n_out = 0;
  int                              burst_left = 0;
  int                              gap_left = 0;

  always #10 clk_i = ~clk_i;

  audio_sample_to_s32 dut (.*);

  // clamp, scale in double precision, then round half away from zero
  function automatic logic [as2s32_pkg::SampleW-1:0] scale_real(real v);
    real    x, fr;
    integer t;
    if (v > 1.0) v = 1.0;
    if (v < -1.0) v = -1.0;
    x  = v * 2147483647.0;
    t  = $rtoi(x);
    fr = x - $itor(t);
    if (fr >= 0.5) t = t + 1;
    if (fr <= -0.5) t = t - 1;
    return t;
  endfunction

  function automatic conv_t convert_sample(logic [as2s32_pkg::RawW-1:0] w);
    conv_t      r;
    logic [7:0] e32;
    r = '0;
    if (cur_tag == as2s32_pkg::TAG_PCM) begin
      case (cur_bits)
        16'd8:   r.smp = {w[7:0] ^ 8'h80, 24'h0};
        16'd16:  r.smp = {w[15:0], 16'h0};
        16'd24:  r.smp = {w[23:0], 8'h0};
        16'd32:  r.smp = w[31:0];
        default: r.bad = 1'b1;
      endcase
    end else if (cur_tag == as2s32_pkg::TAG_FLOAT && cur_bits == 16'd32) begin
      e32 = w[30:23];
      // zero and subnormals scale to well under one half
      if (e32 == 8'h00) r.smp = '0;
      else if (e32 == 8'hFF) begin
        if (w[22:0] != 0) r.smp = '0;
        else r.smp = w[31] ? -as2s32_pkg::FULL_SCALE : as2s32_pkg::FULL_SCALE;
      end
      else r.smp = scale_real($bitstoreal({w[31], 11'(e32) + 11'd896, w[22:0], 29'h0}));
    end else if (cur_tag == as2s32_pkg::TAG_FLOAT && cur_bits == 16'd64) begin
      if (w[62:52] == 11'h7FF && w[51:0] != 0) r.smp = '0;
      else r.smp = scale_real($bitstoreal(w));
    end else begin
      r.bad = 1'b1;
    end
    if (r.bad) r.smp = '0;
    return r;
  endfunction

  function automatic logic [as2s32_pkg::RawW-1:0] rand_word();
    logic [as2s32_pkg::RawW-1:0] w;
    w = {$urandom, $urandom};
    if (cur_tag == as2s32_pkg::TAG_FLOAT && $urandom_range(0, 9) < 8) begin
      // mostly values near full scale so the clamp and rounding get exercised
      if (cur_bits == 16'd32) w[30:23] = 8'($urandom_range(110, 128));
      else w[62:52] = 11'($urandom_range(990, 1024));
    end
    return w;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, n_out);
    n_err++;
  endtask

  task automatic cfg_write(logic [as2s32_pkg::CfgIdxW-1:0] idx,
                           logic [as2s32_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == as2s32_pkg::REG_FORMAT_TAG) cur_tag = val;
    else if (idx == as2s32_pkg::REG_SAMPLE_BITS) cur_bits = val;
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || start_i || sample_q.size() != 0) @(posedge clk_i);
    repeat (as2s32_pkg::PipeDepth + 2) @(posedge clk_i);
  endtask

  // driver: one beat per accept, bursts separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        sample_q.push_back(convert_sample(raw_word_i));
        n_in++;
      end
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() != 0) begin
        go = 1'b1;
        raw_word_i <= word_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start_i <= go;
    end
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    conv_t want;
    if (rst_ni && valid_o) begin
      if (sample_q.size() == 0) begin
        report("unexpected beat", {31'h0, unsupported_o, sample_out_o}, '0);
      end else begin
        want = sample_q.pop_front();
        if (sample_out_o !== want.smp)
          report("sample_out", {32'h0, sample_out_o}, {32'h0, want.smp});
        if (unsupported_o !== want.bad)
          report("unsupported", {63'h0, unsupported_o}, {63'h0, want.bad});
      end
      n_out++;
    end
  end

  initial begin
    logic [as2s32_pkg::CfgDataW-1:0] tags[14] = '{
      as2s32_pkg::TAG_PCM, as2s32_pkg::TAG_PCM, as2s32_pkg::TAG_PCM, as2s32_pkg::TAG_PCM,
      as2s32_pkg::TAG_FLOAT, as2s32_pkg::TAG_FLOAT, 16'h0000, as2s32_pkg::TAG_PCM,
      as2s32_pkg::TAG_PCM, as2s32_pkg::TAG_FLOAT, 16'hFFFF, 16'h0002,
      as2s32_pkg::TAG_FLOAT, as2s32_pkg::TAG_PCM};
    logic [as2s32_pkg::CfgDataW-1:0] depth[14] = '{
      16'd8, 16'd16, 16'd24, 16'd32, 16'd32, 16'd64, 16'd16, 16'd0,
      16'hFFFF, 16'd16, 16'd64, 16'd32, 16'd8, 16'd24};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = -1; ph < 14; ph++) begin
      wait_drained();
      if (ph >= 0) begin
        cfg_write(as2s32_pkg::REG_FORMAT_TAG, tags[ph]);
        cfg_write(as2s32_pkg::REG_SAMPLE_BITS, depth[ph]);
        // writes to indexes past the list must drop
        if (ph == 3) begin
          cfg_write(8'd2, 16'hFFFF);
          cfg_write(8'hFF, 16'h0003);
        end
      end
      // edge words for this format
      word_q.push_back('0);
      word_q.push_back('1);
      if (cur_tag == as2s32_pkg::TAG_PCM) begin
        word_q.push_back(64'hFFFF_FFFF_8080_0080);
        word_q.push_back(64'h0000_0000_7F7F_FF7F);
      end else if (cur_tag == as2s32_pkg::TAG_FLOAT && cur_bits == 16'd32) begin
        word_q.push_back(64'h0000_0000_7F80_0000);    // +inf
        word_q.push_back(64'hFFFF_FFFF_FF80_0000);    // -inf
        word_q.push_back(64'h0000_0000_FFC0_0001);    // nan
        word_q.push_back(64'h0000_0000_3F80_0000);    // 1.0
        word_q.push_back(64'h0000_0000_BF80_0000);    // -1.0
        word_q.push_back(64'h0000_0000_0000_0001);    // subnormal
        word_q.push_back(64'h0000_0000_3F00_0000);    // 0.5
      end else if (cur_tag == as2s32_pkg::TAG_FLOAT && cur_bits == 16'd64) begin
        word_q.push_back(64'h7FF0_0000_0000_0000);
        word_q.push_back(64'hFFF0_0000_0000_0000);
        word_q.push_back(64'h7FF0_0000_0000_0001);
        word_q.push_back(64'hBFF0_0000_0000_0000);
        word_q.push_back(64'h3FE0_0000_0000_0000);
        word_q.push_back(64'h0000_0000_0000_0001);
        word_q.push_back(64'hFFEF_FFFF_FFFF_FFFF);
        word_q.push_back(64'h3E00_0000_0000_0000);    // scales to just under one
      end
      for (int i = 0; i < 125; i++) word_q.push_back(rand_word());
    end
    wait_drained();
    $display("covered %0d input beats and %0d result beats over 15 format settings,",
             n_in, n_out);
    $display("including unsupported pairs, float specials and dropped register indexes");
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
